/* rtl/core/mtrd_pkg.sv */
// Shared types and constants for the Modbus TCP response deframer.
// No dependencies; used by every module in rtl/core.
package mtrd_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] FC_READ_INPUT = 8'h04;
  localparam int         HDR_BYTES     = 6;
  localparam int         PROTO_DONE    = 4;
  localparam int         MIN_LEN       = 2;
  localparam int         MIN_COUNT     = 2;

  typedef enum logic [1:0] {
    KIND_REG_VALUE = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_PROTO_ERR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] transaction_id;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] register_value;
    logic        last;
    logic        length_short;
  } result_t;

endpackage

/* rtl/core/modbus_tcp_response_deframer.sv */
// Modbus TCP response deframer: takes one response byte per cycle (tuser marks
// the first byte of a frame) and gives register values, empty-response and
// protocol-error items. Rate: one input byte per clock while the result queue is
// not full; a result passes through the queue write and then the output register
// on its way to the output. A four-item result queue sits between the parser
// and the output register, so the input keeps flowing until that queue is full
// while the output is stalled.
module modbus_tcp_response_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] transaction_id, [23:16] unit_id,
                                      // [31:24] func_code, [47:32] register_value,
                                      // [48] length_short, [55:49] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);

  logic              accept;
  logic              push;
  mtrd_pkg::result_t push_data;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  mtrd_pkg::result_t q_head;
  mtrd_pkg::result_t out_data;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mtrd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (s_axis_tdata),
    .start_of_frame (s_axis_tuser),
    .push           (push),
    .push_data      (push_data)
  );

  mtrd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mtrd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (out_data)
  );

  assign m_axis_tdata = {7'd0, out_data.length_short, out_data.register_value,
                         out_data.func_code, out_data.unit_id, out_data.transaction_id};
  assign m_axis_tuser = out_data.kind;
  assign m_axis_tlast = out_data.last;

endmodule

/* rtl/core/mtrd_front.sv */
// Byte parser: walks the MBAP header and PDU, one byte per cycle while accept is high.
// Depends on mtrd_pkg; pushes finished result items into the result queue.
module mtrd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                start_of_frame,
  output logic                push,
  output mtrd_pkg::result_t   push_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_UNIT,
    PH_FUNC,
    PH_COUNT,
    PH_DATA
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] held_transaction, held_transaction_next;
  logic [15:0] held_protocol, held_protocol_next;
  logic [15:0] held_length, held_length_next;
  logic [7:0]  held_unit, held_unit_next;
  logic [7:0]  held_function, held_function_next;
  logic [7:0]  data_byte_count, data_byte_count_next;
  logic [7:0]  high_byte, high_byte_next;

  phase_t      ph;
  logic [7:0]  pos;
  logic [7:0]  pos_inc;
  logic        length_short;

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    held_transaction_next = held_transaction;
    held_protocol_next    = held_protocol;
    held_length_next      = held_length;
    held_unit_next        = held_unit;
    held_function_next    = held_function;
    data_byte_count_next  = data_byte_count;
    high_byte_next        = high_byte;
    push                  = 1'b0;
    push_data             = '0;

    // a start mark restarts the header regardless of where we were
    ph           = start_of_frame ? PH_HEADER : phase;
    pos          = start_of_frame ? 8'd0 : byte_position;
    pos_inc      = pos + 8'd1;
    length_short = (held_length < 16'(mtrd_pkg::MIN_LEN));

    push_data.transaction_id = held_transaction;
    push_data.unit_id        = held_unit;
    push_data.func_code      = held_function;
    push_data.length_short   = length_short;
    push_data.last           = 1'b1;
    push_data.kind           = mtrd_pkg::KIND_EMPTY;

    if (accept) begin
      phase_next         = ph;
      byte_position_next = pos;
      unique case (ph)
        PH_HEADER: begin
          case (pos)
            8'd0:    held_transaction_next = {data_byte, 8'h00};
            8'd1:    held_transaction_next = {held_transaction[15:8], data_byte};
            8'd2:    held_protocol_next    = {data_byte, 8'h00};
            8'd3:    held_protocol_next    = {held_protocol[15:8], data_byte};
            8'd4:    held_length_next      = {data_byte, 8'h00};
            default: held_length_next      = {held_length[15:8], data_byte};
          endcase
          byte_position_next = pos_inc;
          if (pos_inc == 8'(mtrd_pkg::PROTO_DONE) && held_protocol_next != 16'd0) begin
            phase_next                = PH_IDLE;
            push                      = 1'b1;
            push_data.kind            = mtrd_pkg::KIND_PROTO_ERR;
            push_data.transaction_id  = held_transaction_next;
            push_data.unit_id         = '0;
            push_data.func_code       = '0;
            push_data.length_short    = 1'b0;
          end else if (pos_inc >= 8'(mtrd_pkg::HDR_BYTES)) begin
            phase_next = PH_UNIT;
          end
        end
        PH_UNIT: begin
          held_unit_next = data_byte;
          phase_next     = PH_FUNC;
        end
        PH_FUNC: begin
          held_function_next = data_byte;
          if (data_byte == mtrd_pkg::FC_READ_INPUT) begin
            phase_next = PH_COUNT;
          end else begin
            phase_next          = PH_IDLE;
            push                = 1'b1;
            push_data.func_code = data_byte;
          end
        end
        PH_COUNT: begin
          data_byte_count_next = data_byte;
          if (data_byte < 8'(mtrd_pkg::MIN_COUNT)) begin
            phase_next = PH_IDLE;
            push       = 1'b1;
          end else begin
            byte_position_next = 8'd0;
            phase_next         = PH_DATA;
          end
        end
        PH_DATA: begin
          byte_position_next = pos_inc;
          if (!pos[0]) begin
            high_byte_next = data_byte;
          end else begin
            push                     = 1'b1;
            push_data.kind           = mtrd_pkg::KIND_REG_VALUE;
            push_data.register_value = {high_byte, data_byte};
            // odd trailing byte never completes a pair, so stop on the last full one
            push_data.last = ({1'b0, pos} + 9'd2) >= {1'b0, data_byte_count};
            if (push_data.last) phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
    end
    held_transaction <= held_transaction_next;
    held_protocol    <= held_protocol_next;
    held_length      <= held_length_next;
    held_unit        <= held_unit_next;
    held_function    <= held_function_next;
    data_byte_count  <= data_byte_count_next;
    high_byte        <= high_byte_next;
  end

endmodule

/* rtl/core/mtrd_fifo.sv */
// Short result queue between the parser and the output stage.
// Depends on mtrd_pkg for depth and the result item type.
module mtrd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mtrd_pkg::result_t   push_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output mtrd_pkg::result_t   head
);

  mtrd_pkg::result_t              mem [mtrd_pkg::FIFO_DEPTH];
  logic [mtrd_pkg::FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [mtrd_pkg::FIFO_CW-1:0]   count;

  assign full      = (count == mtrd_pkg::FIFO_CW'(mtrd_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + mtrd_pkg::FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + mtrd_pkg::FIFO_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + mtrd_pkg::FIFO_CW'(1);
        2'b01:   count <= count - mtrd_pkg::FIFO_CW'(1);
        default: count <= count;
      endcase
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

/* rtl/core/mtrd_back.sv */
// Output register stage: pulls result items from the queue onto the stream.
// Depends on mtrd_pkg for the result item type.
module mtrd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  mtrd_pkg::result_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mtrd_pkg::result_t   out_data
);

  // refill whenever the register is empty or being drained this cycle
  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_not_empty;
    end
    if (q_pop) out_data <= q_head;
  end

endmodule
